// ----- hw/rtl/fwdr_pkg.sv -----
`default_nettype none

package fwdr_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int VALUE_W         = 32;
    localparam int FUNC_W          = 3;
    localparam int STATUS_W        = 2;
    localparam int OCC_W           = 5;
    localparam int M_TDATA_W       = 40;
    localparam int CMDQ_DEPTH      = 2;

    typedef enum logic [FUNC_W-1:0] {
        OP_ENQ  = 3'd0,
        OP_DEL  = 3'd1,
        OP_DEQ  = 3'd2,
        OP_CLR  = 3'd3,
        OP_REV  = 3'd4,
        OP_SHOW = 3'd5,
        OP_NOP  = 3'd6
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_NOTFOUND = 2'd2,
        STAT_FULL     = 2'd3
    } stat_t;

    typedef struct packed {
        op_t                op;
        logic [VALUE_W-1:0] value;
    } cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fifo_with_value_delete_and_reverse.sv -----
`default_nettype none

// Bounded FIFO of signed 32-bit values with enqueue, dequeue, delete-first-match,
// clear, reverse and show. Input transfers carry func in s_tuser and the value in
// s_tdata; a two-entry command queue takes transfers while the engine works, so
// s_tready only drops when two commands are waiting. Each result is one transfer;
// show gives one per stored entry with m_tlast on the final one. The store is a
// single-port-read memory walked one entry per cycle, except while show waits on
// the output. Enqueue, dequeue, clear, reverse and unused selectors do not walk
// it; show walks every stored entry and delete each at most once (search, then
// tail shift). Reverse swaps head and tail and flips the circular walk direction.
module fifo_with_value_delete_and_reverse
#(
    parameter int QUEUE_DEPTH = fwdr_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [fwdr_pkg::VALUE_W-1:0]   s_tdata,   // value
    input  wire logic [fwdr_pkg::FUNC_W-1:0]    s_tuser,   // func
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [fwdr_pkg::M_TDATA_W-1:0]      m_tdata,   // data_out, occupancy, zero pad
    output logic [fwdr_pkg::STATUS_W-1:0]       m_tuser,   // status
    output logic                                m_tlast
);
    import fwdr_pkg::*;

    localparam int PAD_W = M_TDATA_W - VALUE_W - OCC_W;

    logic               cmd_valid;
    logic               cmd_ready;
    cmd_t               cmd;
    logic [VALUE_W-1:0] out_data;
    stat_t              out_status;
    logic [OCC_W-1:0]   out_occ;

    fwdr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    fwdr_back
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data),
        .out_status (out_status),
        .out_occ    (out_occ),
        .out_last   (m_tlast)
    );

    assign m_tdata = {{PAD_W{1'b0}}, out_occ, out_data};
    assign m_tuser = out_status;

    // only show produces more than one result, and all of those are ok
    a_multi_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tuser == STAT_OK)
        else $error("non-final result with error status");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != STAT_OK |-> m_tdata[VALUE_W-1:0] == '0)
        else $error("error result carries data");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == STAT_EMPTY |-> out_occ == '0)
        else $error("empty status with nonzero occupancy");

endmodule

`default_nettype wire

// ----- hw/rtl/fwdr_front.sv -----
`default_nettype none

module fwdr_front
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [fwdr_pkg::VALUE_W-1:0] s_tdata,
    input  wire logic [fwdr_pkg::FUNC_W-1:0]  s_tuser,
    output logic                             cmd_valid,
    input  wire logic                        cmd_ready,
    output fwdr_pkg::cmd_t                   cmd
);
    import fwdr_pkg::*;

    localparam int QW = $clog2(CMDQ_DEPTH);
    localparam int FW = $clog2(CMDQ_DEPTH + 1);

    cmd_t          q_reg [CMDQ_DEPTH];
    logic [QW-1:0] wr_ptr_reg;
    logic [QW-1:0] rd_ptr_reg;
    logic [FW-1:0] fill_reg;
    logic          push;
    logic          pop;
    cmd_t          dec;

    always_comb
    begin
        dec.value = s_tdata;
        case (s_tuser)
            OP_ENQ:  dec.op = OP_ENQ;
            OP_DEL:  dec.op = OP_DEL;
            OP_DEQ:  dec.op = OP_DEQ;
            OP_CLR:  dec.op = OP_CLR;
            OP_REV:  dec.op = OP_REV;
            OP_SHOW: dec.op = OP_SHOW;
            default: dec.op = OP_NOP;
        endcase
    end

    assign s_tready  = (fill_reg != FW'(CMDQ_DEPTH));
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QW'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + FW'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - FW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/fwdr_back.sv -----
`default_nettype none

module fwdr_back
#(
    parameter int QUEUE_DEPTH = fwdr_pkg::QUEUE_DEPTH_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    output logic                               cmd_ready,
    input  wire fwdr_pkg::cmd_t                cmd,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [fwdr_pkg::VALUE_W-1:0]       out_data,
    output fwdr_pkg::stat_t                    out_status,
    output logic [fwdr_pkg::OCC_W-1:0]         out_occ,
    output logic                               out_last
);
    import fwdr_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_EXEC   = 6'b000010,
        ST_SEARCH = 6'b000100,
        ST_SHIFT  = 6'b001000,
        ST_SHOW   = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    function automatic logic [PW-1:0] ptr_fwd(input logic [PW-1:0] p, input logic d);
        logic [PW-1:0] r;
        if (!d)
        begin
            r = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
        end
        else
        begin
            r = (p == '0) ? PW'(QUEUE_DEPTH - 1) : p - PW'(1);
        end
        return r;
    endfunction

    function automatic logic [PW-1:0] ptr_bwd(input logic [PW-1:0] p, input logic d);
        return ptr_fwd(p, !d);
    endfunction

    logic [VALUE_W-1:0] mem [QUEUE_DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;
    logic               wr_en;
    logic [PW-1:0]      wr_addr;
    logic [VALUE_W-1:0] wr_data;

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [PW-1:0]      head_reg, head_next;
    logic [PW-1:0]      tail_reg, tail_next;
    logic [PW-1:0]      p_reg, p_next;
    logic               dir_reg, dir_next;
    logic [VALUE_W-1:0] res_data_reg, res_data_next;
    stat_t              res_status_reg, res_status_next;

    logic               ovalid_reg;
    logic [VALUE_W-1:0] odata_reg;
    stat_t              ostatus_reg;
    logic [OCC_W-1:0]   oocc_reg;
    logic               olast_reg;

    logic               out_free;
    logic               load;
    logic [VALUE_W-1:0] load_data;
    stat_t              load_status;
    logic               load_last;

    assign out_free = !ovalid_reg || out_ready;

    // rd_data_reg holds mem[p_reg], but keeps the old value after a write to that address
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[p_next];
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        value_next      = value_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        p_next          = p_reg;
        dir_next        = dir_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        cmd_ready       = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = tail_reg;
        wr_data         = value_reg;
        load            = 1'b0;
        load_data       = res_data_reg;
        load_status     = res_status_reg;
        load_last       = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                p_next    = head_reg;
                if (cmd_valid)
                begin
                    op_next    = cmd.op;
                    value_next = cmd.value;
                    idx_next   = '0;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                res_data_next   = '0;
                res_status_next = STAT_OK;
                state_next      = ST_DONE;
                case (op_reg)
                    OP_ENQ:
                    begin
                        if (count_reg == CW'(QUEUE_DEPTH))
                        begin
                            res_status_next = STAT_FULL;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            tail_next  = ptr_fwd(tail_reg, dir_reg);
                            count_next = count_reg + CW'(1);
                        end
                    end
                    OP_DEL:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            state_next = ST_SEARCH;
                        end
                    end
                    OP_DEQ:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            res_data_next = rd_data_reg;
                            head_next     = ptr_fwd(head_reg, dir_reg);
                            count_next    = count_reg - CW'(1);
                        end
                    end
                    OP_CLR:
                    begin
                        count_next = '0;
                        tail_next  = head_reg;
                    end
                    OP_REV:
                    begin
                        head_next = ptr_bwd(tail_reg, dir_reg);
                        tail_next = ptr_bwd(head_reg, dir_reg);
                        dir_next  = !dir_reg;
                    end
                    OP_SHOW:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            state_next = ST_SHOW;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_SEARCH:
            begin
                if (rd_data_reg == value_reg)
                begin
                    p_next     = ptr_fwd(p_reg, dir_reg);
                    state_next = ST_SHIFT;
                end
                else if (idx_reg + CW'(1) == count_reg)
                begin
                    res_status_next = STAT_NOTFOUND;
                    state_next      = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                    p_next   = ptr_fwd(p_reg, dir_reg);
                end
            end
            ST_SHIFT:
            begin
                // close the gap: entry idx takes entry idx+1
                if (idx_reg + CW'(1) < count_reg)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = ptr_bwd(p_reg, dir_reg);
                    wr_data  = rd_data_reg;
                    p_next   = ptr_fwd(p_reg, dir_reg);
                    idx_next = idx_reg + CW'(1);
                end
                else
                begin
                    tail_next       = ptr_bwd(tail_reg, dir_reg);
                    count_next      = count_reg - CW'(1);
                    res_status_next = STAT_OK;
                    state_next      = ST_DONE;
                end
            end
            ST_SHOW:
            begin
                load_data   = rd_data_reg;
                load_status = STAT_OK;
                load_last   = (idx_reg + CW'(1) == count_reg);
                if (out_free)
                begin
                    load = 1'b1;
                    if (load_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                        p_next   = ptr_fwd(p_reg, dir_reg);
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            p_reg      <= '0;
            dir_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            p_reg     <= p_next;
            dir_reg   <= dir_next;
            if (load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        value_reg      <= value_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        if (load)
        begin
            odata_reg   <= load_data;
            ostatus_reg <= load_status;
            oocc_reg    <= OCC_W'(count_next);
            olast_reg   <= load_last;
        end
    end

    assign out_valid  = ovalid_reg;
    assign out_data   = odata_reg;
    assign out_status = ostatus_reg;
    assign out_occ    = oocc_reg;
    assign out_last   = olast_reg;

endmodule

`default_nettype wire

// ----- tb/tb_fifo_with_value_delete_and_reverse.sv -----
`timescale 1ns / 1ps

module tb_fifo_with_value_delete_and_reverse;
    import fwdr_pkg::*;

    localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 8;
    localparam logic [FUNC_W-1:0] OP_UNUSED_HI = 3'd7;

    typedef struct {
        logic [VALUE_W-1:0] data_out;
        stat_t              status;
        logic [OCC_W-1:0]   occupancy;
        logic               last;
    } queue_result_t;

    class value_fifo_tracker;
        int unsigned        depth;
        logic [VALUE_W-1:0] stored_values[$];
        queue_result_t      pending_results[$];
        int                 errors;

        function new(int unsigned d);
            depth  = d;
            errors = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void push_result(logic [VALUE_W-1:0] data, stat_t status, logic last);
            queue_result_t r;
            r.data_out  = data;
            r.status    = status;
            r.occupancy = OCC_W'(stored_values.size());
            r.last      = last;
            pending_results.push_back(r);
        endfunction

        function void note_command(logic [FUNC_W-1:0] func, logic [VALUE_W-1:0] value);
            int                 n;
            int                 hit;
            logic [VALUE_W-1:0] tmp;
            n = stored_values.size();
            case (func)
                OP_ENQ:
                begin
                    if (n >= depth)
                        push_result('0, STAT_FULL, 1'b1);
                    else
                    begin
                        stored_values.push_back(value);
                        push_result('0, STAT_OK, 1'b1);
                    end
                end
                OP_DEL:
                begin
                    hit = -1;
                    for (int i = 0; i < n; i++)
                        if (hit < 0 && stored_values[i] == value)
                            hit = i;
                    if (n == 0)
                        push_result('0, STAT_EMPTY, 1'b1);
                    else if (hit < 0)
                        push_result('0, STAT_NOTFOUND, 1'b1);
                    else
                    begin
                        stored_values.delete(hit);
                        push_result('0, STAT_OK, 1'b1);
                    end
                end
                OP_DEQ:
                begin
                    if (n == 0)
                        push_result('0, STAT_EMPTY, 1'b1);
                    else
                    begin
                        tmp = stored_values.pop_front();
                        push_result(tmp, STAT_OK, 1'b1);
                    end
                end
                OP_CLR:
                begin
                    stored_values.delete();
                    push_result('0, STAT_OK, 1'b1);
                end
                OP_REV:
                begin
                    for (int i = 0; i < n / 2; i++)
                    begin
                        tmp                      = stored_values[i];
                        stored_values[i]         = stored_values[n - 1 - i];
                        stored_values[n - 1 - i] = tmp;
                    end
                    push_result('0, STAT_OK, 1'b1);
                end
                OP_SHOW:
                begin
                    if (n == 0)
                        push_result('0, STAT_EMPTY, 1'b1);
                    else
                        for (int i = 0; i < n; i++)
                            push_result(stored_values[i], STAT_OK, i == n - 1);
                end
                default:
                    push_result('0, STAT_OK, 1'b1);
            endcase
        endfunction

        function void check_result(logic [VALUE_W-1:0] data, logic [STATUS_W-1:0] status,
                                   logic [OCC_W-1:0] occupancy, logic last);
            queue_result_t exp;
            if (pending_results.size() == 0)
            begin
                $error("unexpected transfer: data_out %0d status %0d occupancy %0d last %0d",
                       $signed(data), status, occupancy, last);
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            if (data !== exp.data_out)
            begin
                $error("data_out: expected %0d, got %0d", $signed(exp.data_out), $signed(data));
                errors++;
            end
            if (status !== exp.status)
            begin
                $error("status: expected %0d, got %0d", exp.status, status);
                errors++;
            end
            if (occupancy !== exp.occupancy)
            begin
                $error("occupancy: expected %0d, got %0d", exp.occupancy, occupancy);
                errors++;
            end
            if (last !== exp.last)
            begin
                $error("last: expected %0d, got %0d", exp.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [VALUE_W-1:0]   s_tdata  = '0;
    logic [FUNC_W-1:0]    s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    logic                 m_tlast;

    int unsigned send_idle_pct = 36;
    int unsigned recv_idle_pct = 46;
    int unsigned idle_cycles   = 0;

    value_fifo_tracker tracker = new(QUEUE_DEPTH);

    fifo_with_value_delete_and_reverse #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            tracker.check_result(m_tdata[VALUE_W-1:0], m_tuser,
                                 m_tdata[VALUE_W+OCC_W-1:VALUE_W], m_tlast);

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(7);
            2: return -$urandom_range(1, 4);
            default:
                case ($urandom_range(2))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    default: return '0;
                endcase
        endcase
    endfunction

    // mostly hit a stored value so deletes find a match
    function automatic logic [VALUE_W-1:0] delete_value();
        int n;
        n = tracker.stored_values.size();
        if (n != 0 && $urandom_range(99) < 70)
            return tracker.stored_values[$urandom_range(n - 1)];
        return rand_value();
    endfunction

    task automatic send_cmd(input logic [FUNC_W-1:0] func, input logic [VALUE_W-1:0] value);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= value;
        do @(posedge clk); while (!s_tready);
        tracker.note_command(func, value);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (tracker.pending() != 0);
    endtask

    task automatic fill_queue();
        int unsigned burst;
        burst = QUEUE_DEPTH - tracker.stored_values.size() + $urandom_range(1, 3);
        repeat (burst) send_cmd(OP_ENQ, rand_value());
    endtask

    task automatic random_phase(input int unsigned n_items);
        int unsigned sent;
        int unsigned pick;
        sent = 0;
        fill_queue();
        send_cmd(OP_SHOW, $urandom());
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
                fill_queue();
            else if (pick < 38)
                send_cmd(OP_ENQ, rand_value());
            else if (pick < 56)
                send_cmd(OP_DEL, delete_value());
            else if (pick < 71)
                send_cmd(OP_DEQ, $urandom());
            else if (pick < 74)
                send_cmd(OP_CLR, $urandom());
            else if (pick < 83)
                send_cmd(OP_REV, $urandom());
            else if (pick < 94)
                send_cmd(OP_SHOW, $urandom());
            else if (pick < 97)
                send_cmd(OP_NOP, $urandom());
            else
                send_cmd(OP_UNUSED_HI, $urandom());
            sent++;
            if ($urandom_range(39) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty-queue behavior and unused selectors
        send_cmd(OP_SHOW, $urandom());
        send_cmd(OP_DEQ, $urandom());
        send_cmd(OP_DEL, '0);
        send_cmd(OP_CLR, $urandom());
        send_cmd(OP_REV, $urandom());
        send_cmd(OP_NOP, 32'hFFFF_FFFF);
        send_cmd(OP_UNUSED_HI, $urandom());
        // single entry reverse, extremes, duplicate delete, miss
        send_cmd(OP_ENQ, 32'h7FFF_FFFF);
        send_cmd(OP_REV, $urandom());
        send_cmd(OP_SHOW, $urandom());
        send_cmd(OP_ENQ, 32'h8000_0000);
        send_cmd(OP_ENQ, 32'hFFFF_FFFF);
        send_cmd(OP_ENQ, '0);
        send_cmd(OP_ENQ, 32'h8000_0000);
        send_cmd(OP_DEL, 32'h8000_0000);
        send_cmd(OP_DEL, 32'd5);
        send_cmd(OP_REV, $urandom());
        send_cmd(OP_SHOW, $urandom());
        send_cmd(OP_DEQ, $urandom());
        send_cmd(OP_CLR, $urandom());
        send_cmd(OP_SHOW, $urandom());
        wait_drained();

        random_phase(40);
        send_idle_pct = 46;
        recv_idle_pct = 36;
        random_phase(40);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(40);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- fifo_with_value_delete_and_reverse.f -----
hw/rtl/fwdr_pkg.sv
hw/rtl/fwdr_front.sv
hw/rtl/fwdr_back.sv
hw/rtl/fifo_with_value_delete_and_reverse.sv
tb/tb_fifo_with_value_delete_and_reverse.sv
